@@ hw/rtl/msp_pkg.sv @@
// shared types, constants and helpers for the midi stream parser
package msp_pkg;

   localparam int SYSEX_DEPTH = 32;
   localparam int SX_CNT_W    = $clog2(SYSEX_DEPTH + 1);
   localparam int SX_IDX_W    = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;

   localparam logic [7:0] BYTE_SOX     = 8'hf0;
   localparam logic [7:0] BYTE_EOX     = 8'hf7;
   localparam logic [7:0] RT_MASK      = 8'hf8;
   localparam logic [7:0] SYS_MASK     = 8'hf0;
   localparam logic [3:0] LOW_NIBBLE_MASK = 4'hf;

   // parser state codes
   localparam logic [3:0] PS_IDLE   = 4'd0;
   localparam logic [3:0] PS_FIRST  = 4'd1;
   localparam logic [3:0] PS_SECOND = 4'd8;
   localparam logic [3:0] PS_SYSEX  = 4'd15;

   localparam logic [3:0] KIND_RT_BASE = 4'd7;
   localparam logic [3:0] KIND_SYSEX   = 4'd15;

   typedef enum logic [2:0] {
      ST_RUN   = 3'b001,
      ST_FETCH = 3'b010,
      ST_LOAD  = 3'b100
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic drain_start;
      logic load_sysex;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic eox_nonempty;
      logic sysex_last;
   } dp_status_type;

   function automatic logic two_byte_kind(input logic [2:0] kind);
      return (kind <= 3'd3) || (kind == 3'd6);
   endfunction

endpackage

@@ hw/rtl/msp_ctrl.sv @@
// controller state machine: byte intake and sysex dump sequencing
module msp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  msp_pkg::dp_status_type status,
   output msp_pkg::dp_cmd_type   cmd
);

   msp_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      cmd.accept      = 1'b0;
      cmd.drain_start = 1'b0;
      cmd.load_sysex  = 1'b0;
      case (state_ff)
         msp_pkg::ST_RUN: begin
            cmd.accept = req_valid && status.out_free;
            if (cmd.accept && status.eox_nonempty) begin
               cmd.drain_start = 1'b1;
               state_in        = msp_pkg::ST_FETCH;
            end
         end
         msp_pkg::ST_FETCH: begin
            state_in = msp_pkg::ST_LOAD;
         end
         msp_pkg::ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_sysex = 1'b1;
               state_in = status.sysex_last ? msp_pkg::ST_RUN : msp_pkg::ST_FETCH;
            end
         end
         default: begin
            state_in = msp_pkg::ST_RUN;
         end
      endcase
   end

   assign req_stall = !((state_ff == msp_pkg::ST_RUN) && status.out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msp_pkg::ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

   a_drain_enters_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd.drain_start |=> (state_ff == msp_pkg::ST_FETCH) && !cmd.accept)
      else $error("sysex dump did not block intake");

   a_load_only_after_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd.load_sysex |-> $past(state_ff) == msp_pkg::ST_FETCH
                         || $past(state_ff) == msp_pkg::ST_LOAD)
      else $error("sysex word loaded without a fetch");

endmodule

@@ hw/rtl/msp_datapath.sv @@
// parser datapath: decode, running status, sysex buffer and result register
module msp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  msp_pkg::dp_cmd_type   cmd,
   output msp_pkg::dp_status_type status,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_event_kind,
   output logic [3:0]            rsp_channel,
   output logic [6:0]            rsp_first_data,
   output logic [6:0]            rsp_second_data,
   output logic                  rsp_last_of_run
);

   logic [3:0]                    pstate_ff, pstate_in;
   logic [3:0]                    chan_ff, chan_in;
   logic [6:0]                    held_ff, held_in;
   logic [msp_pkg::SX_CNT_W-1:0]  count_ff, count_in;
   logic [msp_pkg::SX_IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [6:0]                    sx_mem [msp_pkg::SYSEX_DEPTH];
   logic [6:0]                    mem_q_ff;
   logic                          mem_we;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [3:0]                    kind_ff, kind_in;
   logic [6:0]                    d1_ff, d1_in, d2_ff, d2_in;
   logic                          last_ff, last_in;

   logic                          res_valid;
   logic [3:0]                    res_kind;
   logic [6:0]                    res_d1, res_d2;
   logic [2:0]                    first_kind, second_kind;

   assign first_kind  = 3'(pstate_ff - msp_pkg::PS_FIRST);
   assign second_kind = 3'(pstate_ff - msp_pkg::PS_SECOND);

   // byte decode
   always_comb begin
      pstate_in = pstate_ff;
      chan_in   = chan_ff;
      held_in   = held_ff;
      count_in  = count_ff;
      mem_we    = 1'b0;
      res_valid = 1'b0;
      res_kind  = 4'd0;
      res_d1    = 7'd0;
      res_d2    = 7'd0;
      if ((req_rx_byte & msp_pkg::RT_MASK) == msp_pkg::RT_MASK) begin
         res_valid = 1'b1;
         res_kind  = 4'(msp_pkg::KIND_RT_BASE + {1'b0, req_rx_byte[2:0]});
      end else if ((req_rx_byte & msp_pkg::SYS_MASK) == msp_pkg::SYS_MASK) begin
         if (req_rx_byte == msp_pkg::BYTE_SOX) begin
            count_in  = '0;
            pstate_in = msp_pkg::PS_SYSEX;
         end else if (req_rx_byte == msp_pkg::BYTE_EOX) begin
            pstate_in = msp_pkg::PS_IDLE;
         end
      end else if (req_rx_byte[7]) begin
         chan_in = req_rx_byte[3:0] & msp_pkg::LOW_NIBBLE_MASK;
         if (pstate_ff == msp_pkg::PS_SYSEX) begin
            count_in = '0;
         end
         pstate_in = 4'(msp_pkg::PS_FIRST + {1'b0, req_rx_byte[6:4]});
      end else if (pstate_ff == msp_pkg::PS_SYSEX) begin
         if (count_ff < msp_pkg::SX_CNT_W'(msp_pkg::SYSEX_DEPTH)) begin
            mem_we   = 1'b1;
            count_in = msp_pkg::SX_CNT_W'(count_ff + 1'b1);
         end else begin
            count_in  = '0;
            pstate_in = msp_pkg::PS_IDLE;
         end
      end else if (pstate_ff >= msp_pkg::PS_FIRST && pstate_ff < msp_pkg::PS_SECOND) begin
         if (msp_pkg::two_byte_kind(first_kind)) begin
            held_in   = req_rx_byte[6:0];
            pstate_in = 4'(msp_pkg::PS_SECOND + {1'b0, first_kind});
         end else begin
            res_valid = 1'b1;
            res_kind  = {1'b0, first_kind};
            res_d1    = req_rx_byte[6:0];
            held_in   = 7'd0;
         end
      end else if (pstate_ff >= msp_pkg::PS_SECOND && pstate_ff < msp_pkg::PS_SYSEX) begin
         held_in = 7'd0;
         if (msp_pkg::two_byte_kind(second_kind)) begin
            res_valid = 1'b1;
            res_kind  = {1'b0, second_kind};
            res_d1    = held_ff;
            res_d2    = req_rx_byte[6:0];
            pstate_in = 4'(msp_pkg::PS_FIRST + {1'b0, second_kind});
         end else begin
            pstate_in = msp_pkg::PS_IDLE;
         end
      end else begin
         held_in = 7'd0;
      end
   end

   assign status.out_free     = !rsp_valid_ff || !rsp_stall;
   assign status.eox_nonempty = (req_rx_byte == msp_pkg::BYTE_EOX) && (count_ff != '0);
   assign status.sysex_last   =
      (msp_pkg::SX_CNT_W'(rd_idx_ff) + msp_pkg::SX_CNT_W'(1)) == count_ff;

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.drain_start) begin
         rd_idx_in = '0;
      end else if (cmd.load_sysex) begin
         rd_idx_in = msp_pkg::SX_IDX_W'(rd_idx_ff + 1'b1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      last_in      = last_ff;
      if (cmd.load_sysex) begin
         rsp_valid_in = 1'b1;
         kind_in      = msp_pkg::KIND_SYSEX;
         d1_in        = mem_q_ff;
         d2_in        = 7'd0;
         last_in      = status.sysex_last;
      end else if (cmd.accept && res_valid) begin
         rsp_valid_in = 1'b1;
         kind_in      = res_kind;
         d1_in        = res_d1;
         d2_in        = res_d2;
         last_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pstate_ff    <= msp_pkg::PS_IDLE;
         chan_ff      <= 4'd0;
         held_ff      <= 7'd0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            pstate_ff <= pstate_in;
            chan_ff   <= chan_in;
            held_ff   <= held_in;
            count_ff  <= count_in;
         end
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      d1_ff   <= d1_in;
      d2_ff   <= d2_in;
      last_ff <= last_in;
   end

   // sysex buffer
   always_ff @(posedge clock) begin
      if (cmd.accept && mem_we) begin
         sx_mem[count_ff[msp_pkg::SX_IDX_W-1:0]] <= req_rx_byte[6:0];
      end
      mem_q_ff <= sx_mem[rd_idx_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_channel     = chan_ff;
   assign rsp_first_data  = d1_ff;
   assign rsp_second_data = d2_ff;
   assign rsp_last_of_run = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= msp_pkg::SX_CNT_W'(msp_pkg::SYSEX_DEPTH))
      else $error("sysex count beyond buffer depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_sysex |-> msp_pkg::SX_CNT_W'(rd_idx_ff) < count_ff)
      else $error("sysex read past written entries");

   a_no_dead_state: assert property (@(posedge clock) disable iff (reset)
      pstate_ff != 4'd12 && pstate_ff != 4'd13)
      else $error("parser reached second-byte state of a one-byte kind");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !cmd.accept && !cmd.load_sysex)
      else $error("result register overwritten while stalled");

endmodule

@@ hw/rtl/midi_stream_parser_top.sv @@
// midi stream parser top level: controller and datapath
// a result is loaded into the output register at the edge that takes its byte
// throughput: one byte per cycle when the output is free; an F7 with n buffered sysex bytes
//   holds off input during the dump: per word a fetch state, then a load state that waits out stalls
// reset: synchronous, clears parser state, channel, held byte, sysex count and
//   the output valid; the sysex buffer is not cleared and needs no clearing pass
module midi_stream_parser_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_event_kind,
   output logic [3:0] rsp_channel,
   output logic [6:0] rsp_first_data,
   output logic [6:0] rsp_second_data,
   output logic       rsp_last_of_run
);

   msp_pkg::dp_cmd_type    cmd;
   msp_pkg::dp_status_type status;

   msp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   msp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_channel     (rsp_channel),
      .rsp_first_data  (rsp_first_data),
      .rsp_second_data (rsp_second_data),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
